>>> design/upq_pkg.sv
// Shared types, constants and status codes for the unsorted-array priority queue.
// No dependencies; every other design file uses it by scoped names.
package upq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] value;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic [4:0]         held_count;
    } rsp_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_CAPTURE,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic insert;
        logic set_full;
        logic set_empty;
        logic scan_start;
        logic scan_read;
        logic capture;
        logic shift_read;
        logic dec_count;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic full;
        logic empty;
        logic scan_issued;
        logic shift_issued;
        logic out_free;
    } stat_t;

endpackage

>>> design/unsorted_array_priority_queue_top.sv
// Top level of the unsorted-array priority queue.
// Depends on upq_pkg, upq_ctrl and upq_datapath.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one item: operation 0
//   inserts req.value, operation 1 removes and returns the smallest held
//   value, the oldest among equal values.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one item per request:
//   status (ok, full, empty), removed_value (zero unless a delete succeeds)
//   and held_count after the operation.
// Timing:
//   delete of n held entries scans all n for the minimum, then shifts the
//   entries behind it down one place; the entry memory has one read port,
//   so the scan reads one entry per cycle and the shift moves one entry
//   per cycle.
//   One item is in work at a time; req_ready is high only while idle.
// Reset: rst_n clears the count, so the queue starts empty; entry contents
//   are not cleared and need no clearing pass.
// Stall: a result waits in the output register while rsp_ready is low; the
//   next request is taken meanwhile and its result waits until the slot frees.
module unsorted_array_priority_queue_top
#(
    parameter int DEPTH = upq_pkg::DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  upq_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output upq_pkg::rsp_item_t rsp
);

    upq_pkg::cmd_t  cmd;
    upq_pkg::stat_t stat;

    upq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    upq_datapath
    #(
        .DEPTH (DEPTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> design/upq_ctrl.sv
// Controller state machine for the priority queue.
// Depends on upq_pkg; drives commands into upq_datapath and reads its status.
module upq_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  upq_pkg::stat_t stat,
    output upq_pkg::cmd_t  cmd
);

    upq_pkg::state_t state_reg;
    upq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= upq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            upq_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = upq_pkg::ST_LOAD;
                end
            end
            upq_pkg::ST_LOAD:
            begin
                if (stat.op == upq_pkg::OP_DELETE && !stat.empty)
                begin
                    state_next = upq_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = upq_pkg::ST_FINISH;
                end
            end
            upq_pkg::ST_SCAN:
            begin
                if (stat.scan_issued)
                begin
                    state_next = upq_pkg::ST_CAPTURE;
                end
            end
            upq_pkg::ST_CAPTURE:
            begin
                state_next = upq_pkg::ST_SHIFT;
            end
            upq_pkg::ST_SHIFT:
            begin
                if (stat.shift_issued)
                begin
                    state_next = upq_pkg::ST_FINISH;
                end
            end
            upq_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = upq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = upq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            upq_pkg::ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.load_in = req_valid;
            end
            upq_pkg::ST_LOAD:
            begin
                if (stat.op == upq_pkg::OP_INSERT)
                begin
                    cmd.set_full = stat.full;
                    cmd.insert   = !stat.full;
                end
                else
                begin
                    cmd.set_empty  = stat.empty;
                    cmd.scan_start = !stat.empty;
                end
            end
            upq_pkg::ST_SCAN:
            begin
                cmd.scan_read = !stat.scan_issued;
            end
            upq_pkg::ST_CAPTURE:
            begin
                cmd.capture = 1'b1;
            end
            upq_pkg::ST_SHIFT:
            begin
                cmd.shift_read = !stat.shift_issued;
                cmd.dec_count  = stat.shift_issued;
            end
            upq_pkg::ST_FINISH:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> design/upq_datapath.sv
// Datapath of the priority queue: entry memory, count, scan and shift pointers,
// running minimum and the result register. Depends on upq_pkg.
module upq_datapath
#(
    parameter int DEPTH = upq_pkg::DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  upq_pkg::req_item_t req,
    output upq_pkg::rsp_item_t rsp,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  upq_pkg::cmd_t      cmd,
    output upq_pkg::stat_t     stat
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    logic               op_reg;
    logic signed [31:0] value_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      ptr_reg;
    logic               cmp_valid_reg;
    logic               best_valid_reg;
    logic [CW-1:0]      best_idx_reg;
    logic signed [31:0] best_val_reg;
    logic [CW-1:0]      cmp_idx_reg;
    logic               sh_valid_reg;
    logic [CW-1:0]      sh_idx_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] removed_reg;
    logic               rsp_valid_reg;
    upq_pkg::rsp_item_t rsp_reg;

    logic [CW:0]        ptr_inc;
    logic [CW-1:0]      rd_addr;
    logic               rd_en;

    assign ptr_inc = {1'b0, ptr_reg} + {{CW{1'b0}}, 1'b1};
    assign rd_en   = cmd.scan_read | cmd.shift_read;
    assign rd_addr = cmd.shift_read ? ptr_inc[CW-1:0] : ptr_reg;

    assign stat.op           = op_reg;
    assign stat.full         = (count_reg == CW'(DEPTH));
    assign stat.empty        = (count_reg == '0);
    assign stat.scan_issued  = (ptr_reg == count_reg);
    assign stat.shift_issued = (ptr_inc >= {1'b0, count_reg});
    assign stat.out_free     = !rsp_valid_reg || rsp_ready;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            mem[count_reg[AW-1:0]] <= value_reg;
        end
        else if (sh_valid_reg)
        begin
            mem[sh_idx_reg[AW-1:0]] <= rd_data_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ptr_reg        <= '0;
            cmp_valid_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
            sh_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= cmd.scan_read;
            sh_valid_reg  <= cmd.shift_read;

            if (cmd.insert)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.dec_count)
            begin
                count_reg <= count_reg - CW'(1);
            end

            if (cmd.scan_start)
            begin
                ptr_reg        <= '0;
                best_valid_reg <= 1'b0;
            end
            else if (cmd.capture)
            begin
                ptr_reg <= best_idx_reg;
            end
            else if (rd_en)
            begin
                ptr_reg <= ptr_inc[CW-1:0];
            end

            // strict less keeps the oldest of equal minima
            if (cmp_valid_reg && (!best_valid_reg || rd_data_reg < best_val_reg))
            begin
                best_valid_reg <= 1'b1;
            end

            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg      <= req.operation;
            value_reg   <= req.value;
            removed_reg <= '0;
            status_reg  <= upq_pkg::STATUS_OK;
        end
        if (cmd.set_full)
        begin
            status_reg <= upq_pkg::STATUS_FULL;
        end
        if (cmd.set_empty)
        begin
            status_reg <= upq_pkg::STATUS_EMPTY;
        end
        if (cmd.scan_read)
        begin
            cmp_idx_reg <= ptr_reg;
        end
        if (cmp_valid_reg && (!best_valid_reg || rd_data_reg < best_val_reg))
        begin
            best_val_reg <= rd_data_reg;
            best_idx_reg <= cmp_idx_reg;
        end
        if (cmd.capture)
        begin
            removed_reg <= best_val_reg;
        end
        if (cmd.shift_read)
        begin
            sh_idx_reg <= ptr_reg;
        end
        if (cmd.out_load)
        begin
            rsp_reg.status        <= status_reg;
            rsp_reg.removed_value <= removed_reg;
            rsp_reg.held_count    <= 5'(count_reg);
        end
    end

endmodule

>>> design/upq_checker.sv
// Port-level checker for the priority queue top, attached by bind.
// Depends on upq_pkg and unsorted_array_priority_queue_top.
module upq_checker
#(
    parameter int DEPTH = upq_pkg::DEPTH_DEFAULT
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input upq_pkg::rsp_item_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp item dropped or changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status == upq_pkg::STATUS_OK
                   || rsp.status == upq_pkg::STATUS_FULL
                   || rsp.status == upq_pkg::STATUS_EMPTY)
        else $error("undefined status code");

    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != upq_pkg::STATUS_OK |-> rsp.removed_value == '0)
        else $error("nonzero removed value on a failed operation");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == upq_pkg::STATUS_FULL |-> rsp.held_count == 5'(DEPTH))
        else $error("full status with a count other than depth");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == upq_pkg::STATUS_EMPTY |-> rsp.held_count == '0)
        else $error("empty status with a nonzero count");

endmodule

bind unsorted_array_priority_queue_top upq_checker
#(
    .DEPTH (DEPTH)
)
u_upq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
